// ===== rtl/buddy_tree_page_allocator_assert.svh =====
// Assertion macros for the buddy tree page allocator.
// Depends on a clock named clk and an active low reset named rst_n in scope.
`ifndef BUDDY_TREE_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_TREE_PAGE_ALLOCATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bta_pkg.sv =====
// Shared constants, codes and helper functions for the buddy tree page allocator.
// No dependencies.
package bta_pkg;

  localparam int MAX_PAGES = 2048;
  localparam int NODE_W    = 12;
  localparam int IDX_W     = 12;
  localparam int NODES     = 2 * MAX_PAGES - 1;
  localparam int OFF_W     = 11;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_BADREQ  = 3'd2;
  localparam logic [2:0] ST_NOINIT  = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;

  localparam logic [NODE_W-1:0] MAX_PAGES_V = NODE_W'(MAX_PAGES);

  // Value of the highest set bit, zero for zero.
  function automatic logic [NODE_W-1:0] hibit(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) r = NODE_W'(1) << i;
    end
    return r;
  endfunction

  // Round up to a power of two; zero and one give one.
  function automatic logic [NODE_W-1:0] roundup_pow2(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] r;
    if (v <= NODE_W'(1)) r = NODE_W'(1);
    else r = hibit(v - NODE_W'(1)) << 1;
    return r;
  endfunction

endpackage

// ===== rtl/buddy_tree_page_allocator.sv =====
// Buddy tree page allocator: top level with the node memory and control sequencer.
// Depends on bta_pkg and buddy_tree_page_allocator_assert.svh.
//
// Usage:
// The input channel takes one operation per beat (opcode, page_count, page_offset);
// the result channel returns one beat per operation (status, block_offset,
// largest_free). A beat moves when valid is high and stall is low.
// usable_pages is written over the APB-style port; the user writes it only while the block is
// idle, as the block does not enforce this. The result beat becomes valid in the same cycle
// that the next beat can be taken. Init sweeps the node memory writing one node a cycle.
// Alloc goes down one level at a time (read left child, then decide) and then climbs back
// up, rewriting each parent from its two children. Free climbs from the leaf to find the
// allocated node, then merges from there up to the root. A rejected operation goes
// straight to the result stage. The node memory has a single read port.
// One operation is in flight at a time; the next is taken once the previous one
// has reached the output register. A stalled result holds in that register.
// Reset clears the initialized flag; every alloc or free before init returns
// status not initialized. The node memory holds no reset value.
module buddy_tree_page_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [11:0]                 in_page_count,
  input  logic [11:0]                 in_page_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [10:0]                 out_block_offset,
  output logic [11:0]                 out_largest_free,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_A_RD, S_A_WT, S_CLIMB, S_F_UP, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   usable_r;
  logic [NODE_W-1:0]   region_r, region_nxt;
  logic                init_r, init_nxt;
  logic [NODE_W-1:0]   root_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NODE_W-1:0]   span_r, span_nxt;
  logic [NODE_W-1:0]   req_r, req_nxt;
  logic [NODE_W-1:0]   pos_r, pos_nxt;
  logic [NODE_W-1:0]   cval_r, cval_nxt;
  logic [NODE_W-1:0]   lim_r, lim_nxt;
  logic                is_free_r, is_free_nxt;
  logic [2:0]          res_status_r, res_status_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic [OFF_W-1:0]    out_off_r;
  logic [NODE_W-1:0]   out_free_r;

  logic [NODE_W-1:0]   mem [NODES];
  logic [NODE_W-1:0]   rdata_r;
  logic                we, re;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [NODE_W-1:0]   wdata;

  logic                cfg_wr;
  logic                in_acc;
  logic [NODE_W-1:0]   n_cap;
  logic [IDX_W-1:0]    parent, sib_cur, sib_par, lchild, rchild;
  logic [NODE_W:0]     pair_sum;
  logic [NODE_W-1:0]   pmax, pval, pspan, init_val;
  logic [NODE_W:0]     pos_end;
  logic [NODE_W:0]     init_last;
  logic [NODE_W:0]     prod;
  logic [NODE_W:0]     off_full;
  logic                load_out;

  assign pready = 1'b1;
  assign prdata = {20'd0, usable_r};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_block_offset = out_off_r;
  assign out_largest_free = out_free_r;

  assign parent  = (idx_r - IDX_W'(1)) >> 1;
  assign sib_cur = idx_r[0] ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
  assign sib_par = parent[0] ? parent + IDX_W'(1) : parent - IDX_W'(1);
  assign lchild  = {idx_r[IDX_W-2:0], 1'b1};
  assign rchild  = {idx_r[IDX_W-2:0], 1'b0} + IDX_W'(2);
  assign pspan   = span_r << 1;
  assign pair_sum = {1'b0, cval_r} + {1'b0, rdata_r};
  assign pmax    = (cval_r > rdata_r) ? cval_r : rdata_r;
  // Free merges two wholly free buddies; otherwise, and always for alloc, the larger child is kept.
  assign pval    = (is_free_r && pair_sum == {1'b0, pspan}) ? pspan : pmax;
  assign n_cap   = (in_page_count > MAX_PAGES_V) ? MAX_PAGES_V : in_page_count;
  assign pos_end = {1'b0, pos_r} + {1'b0, span_r};
  assign init_last = {region_r, 1'b0} - (NODE_W+1)'(2);
  assign prod    = ({1'b0, idx_r} + 13'd1) * {1'b0, span_r};
  assign off_full = prod - {1'b0, region_r};
  assign load_out = !out_valid_r || !out_stall;

  // Node value at init: full span if wholly usable, zero if wholly outside it, else the largest
  // aligned block inside the usable prefix.
  always_comb begin
    if (pos_end <= {1'b0, lim_r}) init_val = span_r;
    else if (pos_r >= lim_r) init_val = '0;
    else init_val = hibit(lim_r - pos_r);
  end

  always_comb begin
    state_nxt = state_r;
    region_nxt = region_r;
    init_nxt = init_r;
    idx_nxt = idx_r;
    span_nxt = span_r;
    req_nxt = req_r;
    pos_nxt = pos_r;
    cval_nxt = cval_r;
    lim_nxt = lim_r;
    is_free_nxt = is_free_r;
    res_status_nxt = res_status_r;
    res_off_nxt = res_off_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = '0;
    re = 1'b0;
    raddr = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = ST_OK;
          res_off_nxt = '0;
          if (in_opcode == OP_INIT) begin
            lim_nxt = (usable_r > MAX_PAGES_V) ? MAX_PAGES_V : usable_r;
            region_nxt = roundup_pow2(lim_nxt);
            span_nxt = region_nxt;
            pos_nxt = '0;
            idx_nxt = '0;
            state_nxt = S_INIT;
          end else if (in_opcode != OP_ALLOC && in_opcode != OP_FREE) begin
            res_status_nxt = ST_BADREQ;
            state_nxt = S_FIN;
          end else if (!init_r) begin
            res_status_nxt = ST_NOINIT;
            state_nxt = S_FIN;
          end else if (in_opcode == OP_ALLOC) begin
            is_free_nxt = 1'b0;
            req_nxt = roundup_pow2(n_cap);
            idx_nxt = '0;
            span_nxt = region_r;
            if (in_page_count == '0 || in_page_count > region_r) begin
              res_status_nxt = ST_BADREQ;
              state_nxt = S_FIN;
            end else if (root_r < req_nxt) begin
              res_status_nxt = ST_NOSPACE;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end else begin
            is_free_nxt = 1'b1;
            if (in_page_offset >= region_r) begin
              res_status_nxt = ST_BADREQ;
              state_nxt = S_FIN;
            end else begin
              idx_nxt = in_page_offset + region_r - IDX_W'(1);
              span_nxt = NODE_W'(1);
              re = 1'b1;
              raddr = idx_nxt;
              state_nxt = S_F_UP;
            end
          end
        end
      end
      S_INIT: begin
        we = 1'b1;
        waddr = idx_r;
        wdata = init_val;
        idx_nxt = idx_r + IDX_W'(1);
        // advance to the next level once this one is covered
        if (pos_end >= {1'b0, region_r}) begin
          pos_nxt = '0;
          span_nxt = span_r >> 1;
        end else begin
          pos_nxt = pos_end[NODE_W-1:0];
        end
        if ({1'b0, idx_r} == init_last || region_r == NODE_W'(1)) begin
          init_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_A_RD: begin
        if (span_r == req_r) begin
          we = 1'b1;
          waddr = idx_r;
          wdata = '0;
          cval_nxt = '0;
          res_off_nxt = off_full[OFF_W-1:0];
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            re = 1'b1;
            raddr = sib_cur;
            state_nxt = S_CLIMB;
          end
        end else begin
          re = 1'b1;
          raddr = lchild;
          state_nxt = S_A_WT;
        end
      end
      S_A_WT: begin
        idx_nxt = (rdata_r >= req_r) ? lchild : rchild;
        span_nxt = span_r >> 1;
        state_nxt = S_A_RD;
      end
      S_F_UP: begin
        if (rdata_r == '0) begin
          we = 1'b1;
          waddr = idx_r;
          wdata = span_r;
          cval_nxt = span_r;
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            re = 1'b1;
            raddr = sib_cur;
            state_nxt = S_CLIMB;
          end
        end else if (idx_r == '0) begin
          res_status_nxt = ST_NOTHING;
          state_nxt = S_FIN;
        end else begin
          idx_nxt = parent;
          span_nxt = pspan;
          re = 1'b1;
          raddr = parent;
        end
      end
      S_CLIMB: begin
        // sibling arrived; the child value is held in cval_r
        we = 1'b1;
        waddr = parent;
        wdata = pval;
        cval_nxt = pval;
        idx_nxt = parent;
        span_nxt = pspan;
        if (parent == '0) begin
          state_nxt = S_FIN;
        end else begin
          re = 1'b1;
          raddr = sib_par;
        end
      end
      S_FIN: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      usable_r <= MAX_PAGES_V;
      region_r <= '0;
      init_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      region_r <= region_nxt;
      init_r <= init_nxt;
      if (cfg_wr) usable_r <= pwdata[NODE_W-1:0];
      if (state_r == S_FIN && load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (we && waddr == '0) root_r <= wdata;
    idx_r <= idx_nxt;
    span_r <= span_nxt;
    req_r <= req_nxt;
    pos_r <= pos_nxt;
    cval_r <= cval_nxt;
    lim_r <= lim_nxt;
    is_free_r <= is_free_nxt;
    res_status_r <= res_status_nxt;
    res_off_r <= res_off_nxt;
    if (state_r == S_FIN && load_out) begin
      out_status_r <= res_status_r;
      out_off_r <= res_off_r;
      out_free_r <= init_r ? root_r : '0;
    end
  end

`include "buddy_tree_page_allocator_assert.svh"

  `BTA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "accepted beat did not start work")
  `BTA_ASSERT_SAME(a_waddr_range, we, waddr <= IDX_W'(NODES - 1), "node write out of range")
  `BTA_ASSERT_SAME(a_err_no_offset, out_valid && out_status != ST_OK, out_block_offset == '0, "error beat carries an offset")
  `BTA_ASSERT_SAME(a_noinit_empty, out_valid && out_status == ST_NOINIT, out_largest_free == '0, "largest free before init")

endmodule
